// ===== rtl/hg_pkg.sv =====
`default_nettype none

package hg_pkg;

  typedef struct packed {
    logic [4:0]  hijri_day;
    logic [3:0]  hijri_month;
    logic [11:0] hijri_year;
  } hijri_date_t;

  typedef struct packed {
    logic [4:0]  civil_day;
    logic [3:0]  civil_month;
    logic [12:0] civil_year;
  } civil_date_t;

  // Pipeline depth, input register to output register.
  localparam int STAGES = 11;

  // Julian day number bounds over every possible input pattern.
  localparam logic [21:0] EPOCH_JD       = 22'(1948440 - 385);
  localparam logic [21:0] GREG_SWITCH_JD = 22'd2299160;
  localparam logic [21:0] JD_MIN         = 22'd1948055;
  localparam logic [21:0] JD_MAX         = 22'd3399660;

  localparam logic [21:0] GREG_OFS = 22'd68569;
  // Offset for the Julian path, already reduced by one for the (j - 1) term.
  localparam logic [21:0] JUL_OFS  = 22'd1401;

  // Constant divisors.
  localparam logic [15:0] DIV_30   = 16'd30;
  localparam logic [23:0] DIV_CENT = 24'd146097;
  localparam logic [21:0] DIV_QUAD = 22'd1461;
  localparam logic [27:0] DIV_YEAR = 28'd1461001;
  localparam logic [15:0] DIV_MON  = 16'd2447;
  localparam logic [15:0] DIV_80   = 16'd80;

  // Reciprocals floor(2^S / C), with 2^S above the largest dividend so that
  // the estimate is low by at most one and one correction step makes it exact.
  localparam logic [11:0] RCP_30   = 12'((2 ** 16) / 30);
  localparam logic [6:0]  RCP_CENT = 7'((2 ** 24) / 146097);
  localparam logic [11:0] RCP_QUAD = 12'((2 ** 22) / 1461);
  localparam logic [7:0]  RCP_YEAR = 8'((2 ** 28) / 1461001);
  localparam logic [4:0]  RCP_MON  = 5'((2 ** 16) / 2447);
  localparam logic [9:0]  RCP_80   = 10'((2 ** 16) / 80);

endpackage

`default_nettype wire

// ===== rtl/hijri_to_gregorian_date_core.sv =====
// Throughput: one date per cycle unless a result waits untaken on civil; the eleven
// register stages each hold one date.
// A result not taken on civil freezes every stage together, input included.
// Reset (rst, synchronous) clears the stage valid bits; data registers are not reset.
`default_nettype none

module hijri_to_gregorian_date_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                hijri_valid,
  output logic                hijri_ready,
  input  hg_pkg::hijri_date_t hijri,
  output logic                civil_valid,
  input  logic                civil_ready,
  output hg_pkg::civil_date_t civil
);
  import hg_pkg::*;

  logic              adv;
  logic [STAGES-1:0] vld;

  // Stage 1: Hijri terms.
  logic [15:0] yr_a_next;
  logic [2:0]  half_m;
  logic [21:0] base1_next;
  logic [27:0] p30_next;
  logic [15:0] s1_a;
  logic [27:0] s1_p;
  logic [21:0] s1_base;

  // Stage 2: Julian day number.
  logic [11:0] q30_est;
  logic [15:0] r30;
  logic [21:0] jd_next;
  logic [21:0] s2_jd;

  // Stage 3: both calendar paths start.
  logic [21:0] lg_next;
  logic [21:0] xj_next;
  logic [30:0] s3_pn;
  logic [33:0] s3_pk;
  logic [21:0] s3_lg;
  logic [21:0] s3_xj;
  logic        s3_greg;

  // Stage 4: quadricentennial and four-year cycle quotients.
  logic [6:0]  n_est;
  logic [23:0] rem_n;
  logic        n_fix;
  logic [23:0] rem_nc;
  logic [11:0] k_est;
  logic [21:0] rem_k;
  logic        k_fix;
  logic [21:0] rem_kc;
  logic [6:0]  s4_n;
  logic [15:0] s4_l2;
  logic [11:0] s4_k;
  logic [10:0] s4_lj;
  logic        s4_greg;

  // Stage 5.
  logic [27:0] xi_next;
  logic [10:0] lj_m1;
  logic [2:0]  nj_next;
  logic [10:0] ij_next;
  logic [27:0] s5_xi;
  logic [35:0] s5_pi;
  logic [15:0] s5_l2;
  logic [6:0]  s5_n;
  logic [11:0] s5_k;
  logic [2:0]  s5_nj;
  logic [8:0]  s5_ij;
  logic        s5_greg;

  // Stage 6.
  logic [7:0]  i_est;
  logic [27:0] rem_i;
  logic [6:0]  s6_i;
  logic [15:0] s6_l2;
  logic [6:0]  s6_n;
  logic [11:0] s6_k;
  logic [2:0]  s6_nj;
  logic [8:0]  s6_ij;
  logic        s6_greg;

  // Stage 7: paths merge.
  logic [17:0] i_days;
  logic [15:0] l3;
  logic [13:0] base_g;
  logic [13:0] base_j;
  logic [8:0]  s7_x;
  logic [12:0] s7_base;

  // Stage 8.
  logic [15:0] x80_next;
  logic [15:0] s8_x80;
  logic [20:0] s8_pj;
  logic [8:0]  s8_x;
  logic [12:0] s8_base;

  // Stage 9.
  logic [4:0]  j_est;
  logic [15:0] rem_j;
  logic [4:0]  s9_j;
  logic [8:0]  s9_x;
  logic [12:0] s9_base;

  // Stage 10.
  logic [15:0] dd_next;
  logic        t_next;
  logic [15:0] s10_dd;
  logic [25:0] s10_pd;
  logic [8:0]  s10_x;
  logic [3:0]  s10_month;
  logic [12:0] s10_year;

  // Stage 11: output register.
  logic [9:0]  q80_est;
  logic [15:0] rem_80;
  logic [9:0]  q80;

  assign adv         = !vld[STAGES-1] || civil_ready;
  assign hijri_ready = adv;
  assign civil_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], hijri_valid};
    end
  end

  always_comb begin
    yr_a_next  = ({4'd0, hijri.hijri_year} * 16'd11) + 16'd3;
    // (M - 1) / 2 truncates toward zero, so month zero gives zero.
    half_m     = (hijri.hijri_month == 4'd0) ? 3'd0 : 3'((hijri.hijri_month - 4'd1) >> 1);
    base1_next = EPOCH_JD + ({10'd0, hijri.hijri_year} * 22'd354)
               + ({18'd0, hijri.hijri_month} * 22'd30)
               - {19'd0, half_m} + {17'd0, hijri.hijri_day};
    p30_next   = {12'd0, yr_a_next} * {16'd0, RCP_30};
  end

  always_comb begin
    q30_est = s1_p[27:16];
    r30     = s1_a - ({4'd0, q30_est} * DIV_30);
    jd_next = s1_base + {10'd0, q30_est} + {21'd0, (r30 >= DIV_30)};
  end

  always_comb begin
    lg_next = s2_jd + GREG_OFS;
    xj_next = s2_jd + JUL_OFS;
  end

  always_comb begin
    n_est  = s3_pn[30:24];
    rem_n  = {s3_lg, 2'b00} - ({17'd0, n_est} * DIV_CENT);
    n_fix  = (rem_n >= DIV_CENT);
    rem_nc = n_fix ? (rem_n - DIV_CENT) : rem_n;
    k_est  = s3_pk[33:22];
    rem_k  = s3_xj - ({10'd0, k_est} * DIV_QUAD);
    k_fix  = (rem_k >= DIV_QUAD);
    rem_kc = k_fix ? (rem_k - DIV_QUAD) : rem_k;
  end

  always_comb begin
    xi_next = ({12'd0, s4_l2} + 28'd1) * 28'd4000;
    lj_m1   = s4_lj - 11'd1;
    // (l - 1) / 365 over 0..1460 by compares, less one at the cycle's last day.
    nj_next = 3'(lj_m1 >= 11'd365) + 3'(lj_m1 >= 11'd730) + 3'(lj_m1 >= 11'd1095)
            + 3'(lj_m1 >= 11'd1460) - 3'(s4_lj == 11'd1461);
    ij_next = s4_lj - ({8'd0, nj_next} * 11'd365) + 11'd30;
  end

  always_comb begin
    i_est = s5_pi[35:28];
    rem_i = s5_xi - ({20'd0, i_est} * DIV_YEAR);
  end

  always_comb begin
    // 1461 * i reaches 18 bits before the divide by four.
    i_days = {11'd0, s6_i} * 18'd1461;
    l3     = s6_l2 - i_days[17:2] + 16'd31;
    base_g = ({7'd0, s6_n} * 14'd100) - 14'd4900 + {7'd0, s6_i};
    base_j = {s6_k, 2'b00} + {11'd0, s6_nj} - 14'd4716;
  end

  assign x80_next = {7'd0, s7_x} * DIV_80;

  always_comb begin
    j_est = s8_pj[20:16];
    rem_j = s8_x80 - ({11'd0, j_est} * DIV_MON);
  end

  always_comb begin
    dd_next = {11'd0, s9_j} * DIV_MON;
    t_next  = (s9_j >= 5'd11);
  end

  always_comb begin
    q80_est = s10_pd[25:16];
    rem_80  = s10_dd - ({6'd0, q80_est} * DIV_80);
    q80     = q80_est + {9'd0, (rem_80 >= DIV_80)};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= yr_a_next;
      s1_p    <= p30_next;
      s1_base <= base1_next;

      s2_jd <= jd_next;

      s3_lg   <= lg_next;
      s3_xj   <= xj_next;
      s3_pn   <= {lg_next, 2'b00, 7'd0} >> 7 == 31'd0 ? 31'd0 :
                 {7'd0, lg_next, 2'b00} * {24'd0, RCP_CENT};
      s3_pk   <= {12'd0, xj_next} * {22'd0, RCP_QUAD};
      s3_greg <= (s2_jd > GREG_SWITCH_JD);

      s4_n    <= n_est + {6'd0, n_fix};
      s4_l2   <= rem_nc[17:2];
      s4_k    <= k_est + {11'd0, k_fix};
      s4_lj   <= rem_kc[10:0] + 11'd1;
      s4_greg <= s3_greg;

      s5_xi   <= xi_next;
      s5_pi   <= {8'd0, xi_next} * {28'd0, RCP_YEAR};
      s5_l2   <= s4_l2;
      s5_n    <= s4_n;
      s5_k    <= s4_k;
      s5_nj   <= nj_next;
      s5_ij   <= ij_next[8:0];
      s5_greg <= s4_greg;

      s6_i    <= 7'(i_est + {7'd0, (rem_i >= DIV_YEAR)});
      s6_l2   <= s5_l2;
      s6_n    <= s5_n;
      s6_k    <= s5_k;
      s6_nj   <= s5_nj;
      s6_ij   <= s5_ij;
      s6_greg <= s5_greg;

      s7_x    <= s6_greg ? l3[8:0] : s6_ij;
      s7_base <= s6_greg ? base_g[12:0] : base_j[12:0];

      s8_x80  <= x80_next;
      s8_pj   <= {5'd0, x80_next} * {16'd0, RCP_MON};
      s8_x    <= s7_x;
      s8_base <= s7_base;

      s9_j    <= j_est + {4'd0, (rem_j >= DIV_MON)};
      s9_x    <= s8_x;
      s9_base <= s8_base;

      s10_dd    <= dd_next;
      s10_pd    <= {10'd0, dd_next} * {16'd0, RCP_80};
      s10_x     <= s9_x;
      s10_month <= 4'(s9_j + 5'd2 - (t_next ? 5'd12 : 5'd0));
      s10_year  <= s9_base + {12'd0, t_next};

      civil.civil_day   <= 5'(s10_x - q80[8:0]);
      civil.civil_month <= s10_month;
      civil.civil_year  <= s10_year;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    hijri_valid && hijri_ready |=> vld[0])
    else $error("accepted transaction did not enter the first stage");

  a_jd_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (s2_jd >= JD_MIN) && (s2_jd <= JD_MAX))
    else $error("Julian day number out of range");

  a_day_of_year_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (s7_x <= 9'd400))
    else $error("day-of-year term out of range after path merge");

  a_month_index_range: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> (s9_j <= 5'd16))
    else $error("month index quotient out of range");

  a_civil_range: assert property (@(posedge clk) disable iff (rst)
    civil_valid |-> (civil.civil_month >= 4'd1) && (civil.civil_month <= 4'd12)
                 && (civil.civil_day >= 5'd1))
    else $error("civil date out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hg_pkg::*;

  typedef struct {
    hijri_date_t date;
    bit          pinned;
    civil_date_t civil;
  } date_row_t;

  localparam int RANDOM_DATES = 450;
  localparam int PACING_MIXES = 4;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        hijri_valid = 1'b0;
  logic        hijri_ready;
  hijri_date_t hijri       = '0;
  logic        civil_valid;
  logic        civil_ready = 1'b0;
  civil_date_t civil;

  // Typed-in answer that travels alongside a directed transaction.
  logic        row_pinned = 1'b0;
  civil_date_t row_civil  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  civil_date_t expected_dates[$];
  date_row_t   directed_rows[$];
  civil_date_t oldest_date;

  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_julian    = 0;
  int n_gregorian = 0;

  hijri_to_gregorian_date_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .hijri_valid(hijri_valid),
    .hijri_ready(hijri_ready),
    .hijri      (hijri),
    .civil_valid(civil_valid),
    .civil_ready(civil_ready),
    .civil      (civil)
  );

  always #2 clk = ~clk;

  function automatic longint hijri_jdn(hijri_date_t h);
    longint d, m, y;
    d = h.hijri_day;
    m = h.hijri_month;
    y = h.hijri_year;
    // Month zero gives (m - 1) / 2 == 0 since signed division truncates toward zero.
    return (11 * y + 3) / 30 + 354 * y + 30 * m - (m - 1) / 2 + d + longint'(EPOCH_JD);
  endfunction

  function automatic civil_date_t convert_to_civil(hijri_date_t h);
    longint jd, l, n, i, j, k, t, d, m, y;
    civil_date_t c;
    jd = hijri_jdn(h);
    if (jd > longint'(GREG_SWITCH_JD)) begin
      l = jd + 68569;
      n = (4 * l) / 146097;
      l = l - (146097 * n + 3) / 4;
      i = (4000 * (l + 1)) / 1461001;
      l = l - (1461 * i) / 4 + 31;
      j = (80 * l) / 2447;
      d = l - (2447 * j) / 80;
      t = j / 11;
      m = j + 2 - 12 * t;
      y = 100 * (n - 49) + i + t;
    end else begin
      j = jd + 1402;
      k = (j - 1) / 1461;
      l = j - 1461 * k;
      n = (l - 1) / 365 - l / 1461;
      i = l - 365 * n + 30;
      j = (80 * i) / 2447;
      d = i - (2447 * j) / 80;
      t = j / 11;
      m = j + 2 - 12 * t;
      y = 4 * k + n + t - 4716;
    end
    c.civil_day   = 5'(d);
    c.civil_month = 4'(m);
    c.civil_year  = 13'(y);
    return c;
  endfunction

  function automatic void add_row(int d, int m, int y, bit pinned = 1'b0,
                                  int cd = 0, int cm = 0, int cy = 0);
    date_row_t r;
    r.date.hijri_day    = 5'(d);
    r.date.hijri_month  = 4'(m);
    r.date.hijri_year   = 12'(y);
    r.pinned            = pinned;
    r.civil.civil_day   = 5'(cd);
    r.civil.civil_month = 4'(cm);
    r.civil.civil_year  = 13'(cy);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic hijri_date_t random_date();
    hijri_date_t h;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // Raw bit patterns, out-of-range values included.
      h.hijri_day   = 5'($urandom);
      h.hijri_month = 4'($urandom);
      h.hijri_year  = 12'($urandom);
    end else if (pick < 30) begin
      // Years around the 1582 calendar switch.
      h.hijri_day   = 5'($urandom_range(30, 1));
      h.hijri_month = 4'($urandom_range(12, 1));
      h.hijri_year  = 12'($urandom_range(995, 985));
    end else begin
      h.hijri_day   = 5'($urandom_range(30, 1));
      h.hijri_month = 4'($urandom_range(12, 1));
      h.hijri_year  = 12'($urandom_range(4095, 1));
    end
    return h;
  endfunction

  task automatic send_date(date_row_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      hijri_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    hijri_valid <= 1'b1;
    hijri       <= r.date;
    row_pinned  <= r.pinned;
    row_civil   <= r.civil;
    @(posedge clk);
    while (!hijri_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    civil_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && civil_valid && civil_ready) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: civil date %0d/%0d/%0d with no transaction outstanding", $time,
                 civil.civil_day, civil.civil_month, civil.civil_year);
        n_errors++;
      end else begin
        oldest_date = expected_dates.pop_front();
        n_checked++;
        if (civil.civil_day !== oldest_date.civil_day ||
            civil.civil_month !== oldest_date.civil_month ||
            civil.civil_year !== oldest_date.civil_year) begin
          $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d", $time,
                   oldest_date.civil_day, oldest_date.civil_month, oldest_date.civil_year,
                   civil.civil_day, civil.civil_month, civil.civil_year);
          n_errors++;
        end
      end
    end
    if (!rst && hijri_valid && hijri_ready) begin
      n_accepted++;
      if (hijri_jdn(hijri) > longint'(GREG_SWITCH_JD)) n_gregorian++;
      else n_julian++;
      expected_dates.insert(expected_dates.size(),
                            row_pinned ? row_civil : convert_to_civil(hijri));
    end
  end

  initial begin
    date_row_t r;
    int mix;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Epoch, all-zero input, and the two days that straddle the calendar switch.
    add_row(1, 1, 1, 1'b1, 16, 7, 622);
    add_row(0, 0, 0, 1'b1, 26, 6, 621);
    add_row(16, 9, 990, 1'b1, 4, 10, 1582);
    add_row(17, 9, 990, 1'b1, 15, 10, 1582);
    add_row(15, 9, 990);
    add_row(18, 9, 990);
    add_row(31, 15, 4095);
    add_row(30, 12, 4095);
    add_row(0, 0, 4095);
    add_row(1, 1, 4095);
    add_row(0, 1, 1445);
    add_row(31, 12, 1445);
    add_row(15, 0, 1000);
    add_row(10, 13, 2000);
    add_row(10, 14, 2000);
    add_row(10, 15, 2000);
    add_row(1, 1, 2048);
    add_row(29, 12, 1444);
    add_row(1, 1, 1446);
    add_row(30, 1, 1);
    foreach (directed_rows[idx]) send_date(directed_rows[idx]);

    for (mix = 0; mix < PACING_MIXES; mix++) begin
      case (mix)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (RANDOM_DATES / PACING_MIXES) begin
        r.date   = random_date();
        r.pinned = 1'b0;
        r.civil  = '0;
        send_date(r);
      end
    end
    hijri_valid <= 1'b0;
    @(posedge clk);

    while (expected_dates.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (STAGES + 8) @(posedge clk);

    if (expected_dates.size() != 0) begin
      $display("%0t: %0d transactions never produced a result", $time,
               expected_dates.size());
      n_errors++;
    end

    $display("Converted %0d dates: %0d on the Julian path, %0d on the Gregorian path,",
             n_checked, n_julian, n_gregorian);
    $display("under four sender and receiver pacing mixes.");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d transactions outstanding.", expected_dates.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
